FILE: src/vrrp_pkg.sv
// ----------------------------------------------------------------------------
// vrrp_pkg: shared types and codes for the VRRP role machine
// Word layouts, role and event codes, register indexes and timing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vrrp_pkg;

	// role codes
	localparam logic [1:0] ROLE_INIT   = 2'd0;
	localparam logic [1:0] ROLE_BACKUP = 2'd1;
	localparam logic [1:0] ROLE_MASTER = 2'd2;

	// event codes
	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_ADVERT = 2'd1;
	localparam logic [1:0] FUNC_START  = 2'd2;

	// register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_PRIORITY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ADV_INTERVAL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS    = 2'd3;
	localparam int unsigned CFG_DATA_W = 32;

	// register reset values
	localparam logic [7:0]  RST_OWN_PRIORITY   = 8'd100;
	localparam logic [7:0]  RST_ADV_INTERVAL   = 8'd1;
	localparam logic        RST_PREEMPT_ENABLE = 1'b1;
	localparam logic [31:0] RST_OWN_ADDRESS    = 32'd0;

	// timing
	localparam int unsigned ADV_TIMER_W = 16;
	localparam int unsigned MD_TIMER_W  = 18;
	localparam logic [7:0]  PRIO_OWNER  = 8'd255;
	localparam logic [7:0]  PRIO_ZERO   = 8'd0;
	localparam logic [8:0]  TICKS_PER_SEC = 9'd256;

	typedef struct packed {
		logic [1:0]  func;
		logic        packet_ok;
		logic [7:0]  packet_priority;
		logic [31:0] packet_source;
		logic        link_alive;
		logic        fault_flag;
	} in_word_t;

	typedef struct packed {
		logic [1:0] role;
		logic       send_advert;
		logic       role_changed;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  own_priority;
		logic [7:0]  adv_interval;
		logic        preempt_enable;
		logic [31:0] own_address;
	} cfg_t;

endpackage

`default_nettype wire

FILE: src/vrrp_master_backup_fsm_unit.sv
// ----------------------------------------------------------------------------
// vrrp_master_backup_fsm_unit: VRRP init / backup / master role machine
// One event word in, one result word out.
// ----------------------------------------------------------------------------
// Path: input accept to out_valid passes the input register, then the
//   result register.
// Throughput: 1 word per cycle unless out_stall holds the result register;
//   the role/timer update is combinational between the two registers.
// Reset (arst_n low): role init, both timers 0, registers at their defaults,
//   pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module vrrp_master_backup_fsm_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// event word in
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire vrrp_pkg::in_word_t                in_data,
	// result word out
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output vrrp_pkg::out_word_t                    out_data,
	// configuration writes
	input  wire logic                              cfg_we,
	input  wire logic [vrrp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [vrrp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	logic                 valid_s1;
	vrrp_pkg::in_word_t   data_s1;
	logic                 out_valid_q;
	vrrp_pkg::out_word_t  out_data_q;
	logic                 accept_in;
	logic                 advance;
	vrrp_pkg::cfg_t       cfg;
	vrrp_pkg::out_word_t  result;

	// Stage 1 moves into the result register when that register is empty or
	// being drained this cycle. Role state commits on the same edge, so each
	// word sees the state left by the one before it.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			data_s1 <= in_data;
		end
	end

	vrrp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	vrrp_role_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (data_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Result register: holds while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

FILE: src/vrrp_cfg_regs.sv
// ----------------------------------------------------------------------------
// vrrp_cfg_regs: configuration register file
// Four write-only registers loaded through a plain indexed write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrrp_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [vrrp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [vrrp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output vrrp_pkg::cfg_t                         cfg
);

	vrrp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_priority   <= vrrp_pkg::RST_OWN_PRIORITY;
			cfg_q.adv_interval   <= vrrp_pkg::RST_ADV_INTERVAL;
			cfg_q.preempt_enable <= vrrp_pkg::RST_PREEMPT_ENABLE;
			cfg_q.own_address    <= vrrp_pkg::RST_OWN_ADDRESS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vrrp_pkg::CFG_OWN_PRIORITY:   cfg_q.own_priority   <= cfg_wdata[7:0];
				vrrp_pkg::CFG_ADV_INTERVAL:   cfg_q.adv_interval   <= cfg_wdata[7:0];
				vrrp_pkg::CFG_PREEMPT_ENABLE: cfg_q.preempt_enable <= cfg_wdata[0];
				vrrp_pkg::CFG_OWN_ADDRESS:    cfg_q.own_address    <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: src/vrrp_role_core.sv
// ----------------------------------------------------------------------------
// vrrp_role_core: role state, timers and next-state logic
// Evaluates one event against the current role and timers; state commits
// when the pipeline advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrrp_role_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire vrrp_pkg::in_word_t  item,
	input  wire vrrp_pkg::cfg_t      cfg,
	output vrrp_pkg::out_word_t      result
);

	logic [1:0]                        role_q, role_d;
	logic [vrrp_pkg::ADV_TIMER_W-1:0]  adv_timer_q, adv_timer_d;
	logic [vrrp_pkg::MD_TIMER_W-1:0]   md_timer_q, md_timer_d;
	logic                              send;
	logic [vrrp_pkg::ADV_TIMER_W-1:0]  adv_ticks;
	logic [8:0]                        skew_ticks;
	logic [vrrp_pkg::MD_TIMER_W-1:0]   md_ticks;
	logic                              outranked;
	logic                              adv_expired;
	logic                              md_expired;

	// interval * 256, skew = 256 - prio, master-down = 3 * interval * 256 + skew
	assign adv_ticks  = {cfg.adv_interval, 8'h00};
	assign skew_ticks = vrrp_pkg::TICKS_PER_SEC - {1'b0, cfg.own_priority};
	assign md_ticks   = {1'b0, cfg.adv_interval, 9'h000}
	                  + {2'b00, cfg.adv_interval, 8'h00}
	                  + {9'h000, skew_ticks};

	assign outranked = (item.packet_priority > cfg.own_priority) ||
	                   ((item.packet_priority == cfg.own_priority) &&
	                    (item.packet_source > cfg.own_address));

	// timer holding 0 or 1 expires on the tick
	assign adv_expired = (adv_timer_q[vrrp_pkg::ADV_TIMER_W-1:1] == '0);
	assign md_expired  = (md_timer_q[vrrp_pkg::MD_TIMER_W-1:1] == '0);

	always_comb begin
		role_d      = role_q;
		adv_timer_d = adv_timer_q;
		md_timer_d  = md_timer_q;
		send        = 1'b0;
		unique case (item.func)
			vrrp_pkg::FUNC_START: begin
				if (cfg.own_priority == vrrp_pkg::PRIO_OWNER && !item.fault_flag) begin
					send        = 1'b1;
					adv_timer_d = adv_ticks;
					role_d      = vrrp_pkg::ROLE_MASTER;
				end else begin
					md_timer_d = md_ticks;
					role_d     = vrrp_pkg::ROLE_BACKUP;
				end
			end
			vrrp_pkg::FUNC_TICK: begin
				if (role_q == vrrp_pkg::ROLE_MASTER) begin
					if (adv_expired) begin
						if (!item.link_alive || item.fault_flag) begin
							md_timer_d = md_ticks;
							role_d     = vrrp_pkg::ROLE_BACKUP;
						end else begin
							send        = 1'b1;
							adv_timer_d = adv_ticks;
						end
					end else begin
						adv_timer_d = adv_timer_q - vrrp_pkg::ADV_TIMER_W'(1);
					end
				end else if (role_q == vrrp_pkg::ROLE_BACKUP) begin
					if (md_expired) begin
						if (item.link_alive && !item.fault_flag) begin
							send        = 1'b1;
							adv_timer_d = adv_ticks;
							role_d      = vrrp_pkg::ROLE_MASTER;
						end else begin
							md_timer_d = md_ticks;
						end
					end else begin
						md_timer_d = md_timer_q - vrrp_pkg::MD_TIMER_W'(1);
					end
				end
			end
			vrrp_pkg::FUNC_ADVERT: begin
				if (item.packet_ok) begin
					if (role_q == vrrp_pkg::ROLE_MASTER) begin
						if (item.packet_priority == vrrp_pkg::PRIO_ZERO) begin
							send        = 1'b1;
							adv_timer_d = adv_ticks;
						end else if (outranked || item.fault_flag || !item.link_alive) begin
							md_timer_d = md_ticks;
							role_d     = vrrp_pkg::ROLE_BACKUP;
						end
					end else if (role_q == vrrp_pkg::ROLE_BACKUP) begin
						if (item.packet_priority == vrrp_pkg::PRIO_ZERO) begin
							md_timer_d = {9'h000, skew_ticks};
						end else if (!cfg.preempt_enable ||
						             item.packet_priority >= cfg.own_priority) begin
							md_timer_d = md_ticks;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q      <= vrrp_pkg::ROLE_INIT;
			adv_timer_q <= '0;
			md_timer_q  <= '0;
		end else if (advance) begin
			role_q      <= role_d;
			adv_timer_q <= adv_timer_d;
			md_timer_q  <= md_timer_d;
		end
	end

	assign result.role         = role_d;
	assign result.send_advert  = send;
	assign result.role_changed = (role_d != role_q);

endmodule

`default_nettype wire

FILE: src/vrrp_checker.sv
// ----------------------------------------------------------------------------
// vrrp_checker: port-level checks for the role machine
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrrp_checker (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_stall,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire vrrp_pkg::out_word_t   out_data
);

	// stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// an advert is only sent by a master
	a_send_master: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.send_advert |-> out_data.role == vrrp_pkg::ROLE_MASTER)
		else $error("advert sent outside master role");

	// no event ever moves the role back to init
	a_no_init_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.role_changed |-> out_data.role != vrrp_pkg::ROLE_INIT)
		else $error("role changed into init");

	// with the result register empty the input side never stalls
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

endmodule

bind vrrp_master_backup_fsm_unit vrrp_checker u_vrrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the VRRP role machine
// A queue of event words feeds a clocked driver; a clocked monitor predicts
// the role, advert and role-change result of every accepted event and checks
// each result word against it. Registers are rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	// event code with no meaning, the block must ignore it
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int unsigned N_PHASES = 8;

	// random phases: one register setting each, extremes included
	localparam logic [7:0] PH_PRIO [N_PHASES] = '{8'd255, 8'd254, 8'd250, 8'd1,
		8'd0, 8'd255, 8'd200, 8'd100};
	localparam logic [7:0] PH_ADV [N_PHASES] = '{8'd0, 8'd0, 8'd0, 8'd0,
		8'd1, 8'd1, 8'd255, 8'd2};
	localparam logic PH_PREEMPT [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0,
		1'b1, 1'b0, 1'b1, 1'b0};
	localparam bit PH_NO_IDLE [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0,
		1'b1, 1'b0, 1'b0, 1'b0};
	localparam int unsigned PH_LEN [N_PHASES] = '{200, 200, 200, 200,
		200, 250, 100, 250};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	vrrp_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	vrrp_pkg::out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [vrrp_pkg::CFG_IDX_W-1:0] cfg_index = vrrp_pkg::CFG_OWN_PRIORITY;
	logic [vrrp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	vrrp_pkg::in_word_t event_q [$];      // event words waiting to be driven
	vrrp_pkg::out_word_t outcome_q [$];   // predicted result words, oldest first

	bit idle_off = 1'b0;        // set per phase: no gaps, no stalls
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned n_mismatch = 0;
	int unsigned n_checked = 0;
	int unsigned cycles = 0;

	// predictor copy of the registers and of the role machine
	logic [7:0] m_prio = vrrp_pkg::RST_OWN_PRIORITY;
	logic [7:0] m_adv = vrrp_pkg::RST_ADV_INTERVAL;
	logic m_preempt = vrrp_pkg::RST_PREEMPT_ENABLE;
	logic [31:0] m_addr = vrrp_pkg::RST_OWN_ADDRESS;
	logic [1:0] m_role = vrrp_pkg::ROLE_INIT;
	logic [vrrp_pkg::ADV_TIMER_W-1:0] m_adv_tmr = '0;
	logic [vrrp_pkg::MD_TIMER_W-1:0] m_md_tmr = '0;

	vrrp_master_backup_fsm_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		n_mismatch++;
	endtask

	// ---------------------------------------------------------------- predictor
	// skew is 256 - priority; master-down adds three advert intervals
	function automatic logic [vrrp_pkg::MD_TIMER_W-1:0] skew_ticks();
		return vrrp_pkg::MD_TIMER_W'(256 - int'(m_prio));
	endfunction

	function automatic logic [vrrp_pkg::MD_TIMER_W-1:0] master_down_ticks();
		return vrrp_pkg::MD_TIMER_W'(3 * 256 * int'(m_adv) + 256 - int'(m_prio));
	endfunction

	// entering master always sends an advert, so the send flag comes back
	function automatic logic to_master();
		m_adv_tmr = {m_adv, 8'd0};
		m_role = vrrp_pkg::ROLE_MASTER;
		return 1'b1;
	endfunction

	function automatic void to_backup();
		m_md_tmr = master_down_ticks();
		m_role = vrrp_pkg::ROLE_BACKUP;
	endfunction

	function automatic vrrp_pkg::out_word_t apply_event(input vrrp_pkg::in_word_t ev);
		vrrp_pkg::out_word_t r;
		logic [1:0] old_role;
		logic snd;
		logic outranked;
		old_role = m_role;
		snd = 1'b0;
		outranked = (ev.packet_priority > m_prio) ||
			(ev.packet_priority == m_prio && ev.packet_source > m_addr);
		case (ev.func)
			vrrp_pkg::FUNC_START: begin
				// start re-decides from any role, init included
				if (m_prio == vrrp_pkg::PRIO_OWNER && !ev.fault_flag)
					snd = to_master();
				else
					to_backup();
			end
			vrrp_pkg::FUNC_TICK: begin
				// a timer at 0 or 1 expires; init ignores ticks
				if (m_role == vrrp_pkg::ROLE_MASTER) begin
					if (m_adv_tmr <= 1) begin
						if (!ev.link_alive || ev.fault_flag)
							to_backup();
						else
							snd = to_master();
					end else begin
						m_adv_tmr = m_adv_tmr - 1'b1;
					end
				end else if (m_role == vrrp_pkg::ROLE_BACKUP) begin
					if (m_md_tmr <= 1) begin
						if (ev.link_alive && !ev.fault_flag)
							snd = to_master();
						else
							m_md_tmr = master_down_ticks();
					end else begin
						m_md_tmr = m_md_tmr - 1'b1;
					end
				end
			end
			vrrp_pkg::FUNC_ADVERT: begin
				if (ev.packet_ok && m_role == vrrp_pkg::ROLE_MASTER) begin
					// priority 0 means the old master quit: advertise now
					if (ev.packet_priority == vrrp_pkg::PRIO_ZERO)
						snd = to_master();
					else if (outranked || ev.fault_flag || !ev.link_alive)
						to_backup();
				end else if (ev.packet_ok && m_role == vrrp_pkg::ROLE_BACKUP) begin
					if (ev.packet_priority == vrrp_pkg::PRIO_ZERO)
						m_md_tmr = skew_ticks();
					else if (!m_preempt || ev.packet_priority >= m_prio)
						m_md_tmr = master_down_ticks();
				end
			end
			default: ;
		endcase
		r.role = m_role;
		r.send_advert = snd;
		r.role_changed = (m_role != old_role);
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus
	function automatic vrrp_pkg::in_word_t mk_event(input logic [1:0] func,
			input logic ok, input logic [7:0] pri, input logic [31:0] src,
			input logic alive, input logic fault);
		vrrp_pkg::in_word_t e;
		e.func = func;
		e.packet_ok = ok;
		e.packet_priority = pri;
		e.packet_source = src;
		e.link_alive = alive;
		e.fault_flag = fault;
		return e;
	endfunction

	// Mostly ticks and adverts aimed at the tie-break region around our own
	// priority and address; every field is random underneath.
	function automatic vrrp_pkg::in_word_t rand_event(input logic [7:0] prio,
			input logic [31:0] addr);
		vrrp_pkg::in_word_t e;
		int unsigned k;
		e.packet_source = $urandom;
		e.packet_priority = 8'($urandom_range(0, 255));
		e.packet_ok = ($urandom_range(0, 9) != 0);
		e.link_alive = ($urandom_range(0, 15) != 0);
		e.fault_flag = ($urandom_range(0, 15) == 0);
		k = $urandom_range(0, 99);
		if (k < 3)
			e.func = vrrp_pkg::FUNC_START;
		else if (k < 5)
			e.func = FUNC_UNUSED;
		else if (k < 80)
			e.func = vrrp_pkg::FUNC_TICK;
		else
			e.func = vrrp_pkg::FUNC_ADVERT;
		case ($urandom_range(0, 7))
			0: e.packet_priority = vrrp_pkg::PRIO_ZERO;
			1: e.packet_priority = prio;
			2: e.packet_priority = prio - 8'd1;
			3: e.packet_priority = prio + 8'd1;
			4: e.packet_priority = vrrp_pkg::PRIO_OWNER;
			default: ;
		endcase
		case ($urandom_range(0, 5))
			0, 1: e.packet_source = addr;
			2: e.packet_source = addr + 32'd1;
			3: e.packet_source = addr - 32'd1;
			default: ;
		endcase
		return e;
	endfunction

	task automatic write_reg(input logic [vrrp_pkg::CFG_IDX_W-1:0] idx,
			input logic [vrrp_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
	endtask

	// unused upper data bits are random: the block must ignore them
	task automatic set_regs(input logic [7:0] prio, input logic [7:0] adv,
			input logic pre, input logic [31:0] addr);
		write_reg(vrrp_pkg::CFG_OWN_PRIORITY, {24'($urandom), prio});
		write_reg(vrrp_pkg::CFG_ADV_INTERVAL, {24'($urandom), adv});
		write_reg(vrrp_pkg::CFG_PREEMPT_ENABLE, {31'($urandom), pre});
		write_reg(vrrp_pkg::CFG_OWN_ADDRESS, addr);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every queued word is in and every result is out, then
	// let the two-stage pipe settle before touching the registers
	task automatic drain();
		do @(negedge clk);
		while (event_q.size() != 0 || in_valid || outcome_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- driver
	// Queue and idle flag are only touched on the falling edge by the
	// stimulus, so the driver sees them settled here.
	always @(posedge clk or negedge arst_n) begin : drv
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (event_q.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= event_q.pop_front();
				gap_left <= idle_off ? 0 : $urandom_range(0, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	// Register writes, predictions and checks live in one block so their
	// order within an edge is fixed: predict first, then check.
	always @(posedge clk or negedge arst_n) begin : mon
		vrrp_pkg::out_word_t got;
		vrrp_pkg::out_word_t want;
		int unsigned n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			m_prio = vrrp_pkg::RST_OWN_PRIORITY;
			m_adv = vrrp_pkg::RST_ADV_INTERVAL;
			m_preempt = vrrp_pkg::RST_PREEMPT_ENABLE;
			m_addr = vrrp_pkg::RST_OWN_ADDRESS;
			m_role = vrrp_pkg::ROLE_INIT;
			m_adv_tmr = '0;
			m_md_tmr = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					vrrp_pkg::CFG_OWN_PRIORITY:   m_prio = cfg_wdata[7:0];
					vrrp_pkg::CFG_ADV_INTERVAL:   m_adv = cfg_wdata[7:0];
					vrrp_pkg::CFG_PREEMPT_ENABLE: m_preempt = cfg_wdata[0];
					vrrp_pkg::CFG_OWN_ADDRESS:    m_addr = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				outcome_q.push_back(apply_event(in_data));
			if (out_valid && !out_stall) begin
				got = out_data;
				if (outcome_q.size() == 0) begin
					report_mismatch($sformatf("result with none pending: role %0d send %0b chg %0b",
						got.role, got.send_advert, got.role_changed));
				end else begin
					want = outcome_q.pop_front();
					if (got.role !== want.role)
						report_mismatch($sformatf("word %0d role got %0d want %0d",
							n_checked, got.role, want.role));
					if (got.send_advert !== want.send_advert)
						report_mismatch($sformatf("word %0d send_advert got %0b want %0b",
							n_checked, got.send_advert, want.send_advert));
					if (got.role_changed !== want.role_changed)
						report_mismatch($sformatf("word %0d role_changed got %0b want %0b",
							n_checked, got.role_changed, want.role_changed));
				end
				n_checked++;
				// random back-pressure for the next word, none with idle_off set
				n = idle_off ? 0 : $urandom_range(0, 3);
				stall_left <= n;
				out_stall <= (n != 0);
			end else if (stall_left > 1) begin
				stall_left <= stall_left - 1;
			end else begin
				stall_left <= 0;
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles,
				outcome_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin : stim
		int unsigned p;
		logic [31:0] addr;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: priority 100, one second, preempt on, address 0.
		@(negedge clk);
		event_q.push_back(mk_event(vrrp_pkg::FUNC_TICK, 1'b1, 8'd0, 32'd0,
			1'b1, 1'b0));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_ADVERT, 1'b1, 8'd200, 32'd5,
			1'b1, 1'b0));
		event_q.push_back(mk_event(FUNC_UNUSED, 1'b1, 8'd255, '1, 1'b1, 1'b1));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_START, 1'b0, 8'd0, 32'd0,
			1'b1, 1'b0));
		// invalid advert ignored even when it would outrank us
		event_q.push_back(mk_event(vrrp_pkg::FUNC_ADVERT, 1'b0, 8'd255, '1,
			1'b1, 1'b0));
		// priority 0: master-down shrinks to the skew time
		event_q.push_back(mk_event(vrrp_pkg::FUNC_ADVERT, 1'b1, vrrp_pkg::PRIO_ZERO,
			32'd1, 1'b1, 1'b0));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_ADVERT, 1'b1, 8'd50, 32'd1,
			1'b1, 1'b0));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_ADVERT, 1'b1, 8'd100, 32'd1,
			1'b1, 1'b0));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_START, 1'b1, 8'd0, 32'd0,
			1'b0, 1'b1));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_TICK, 1'b0, 8'd0, 32'd0,
			1'b0, 1'b0));
		drain();

		// Address owner, zero interval, preempt off, all-ones address:
		// both timers run out on the first tick.
		set_regs(vrrp_pkg::PRIO_OWNER, 8'd0, 1'b0, '1);
		@(negedge clk);
		event_q.push_back(mk_event(vrrp_pkg::FUNC_START, 1'b0, 8'd0, 32'd0,
			1'b1, 1'b1));
		// backup expiry with link down: stay and reload
		event_q.push_back(mk_event(vrrp_pkg::FUNC_TICK, 1'b0, 8'd0, 32'd0,
			1'b0, 1'b0));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_TICK, 1'b0, 8'd0, 32'd0,
			1'b1, 1'b0));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_TICK, 1'b1, 8'd255, '1,
			1'b1, 1'b0));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_ADVERT, 1'b1, vrrp_pkg::PRIO_ZERO,
			32'd0, 1'b1, 1'b0));
		// equal priority, equal address: no one outranks
		event_q.push_back(mk_event(vrrp_pkg::FUNC_ADVERT, 1'b1, 8'd255, '1,
			1'b1, 1'b0));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_ADVERT, 1'b1, 8'd255,
			32'hFFFF_FFFE, 1'b1, 1'b1));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_START, 1'b0, 8'd0, 32'd0,
			1'b1, 1'b0));
		// master expiry with link down: to backup, no advert
		event_q.push_back(mk_event(vrrp_pkg::FUNC_TICK, 1'b0, 8'd0, 32'd0,
			1'b0, 1'b0));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_ADVERT, 1'b1, 8'd1, 32'd0,
			1'b1, 1'b0));
		event_q.push_back(mk_event(FUNC_UNUSED, 1'b0, 8'd0, 32'd0, 1'b0, 1'b0));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_START, 1'b1, 8'd0, 32'd0,
			1'b1, 1'b0));
		event_q.push_back(mk_event(vrrp_pkg::FUNC_ADVERT, 1'b0, 8'd255, '1,
			1'b1, 1'b0));
		drain();

		// random phases, each opened with a start so the role leaves init
		for (p = 0; p < N_PHASES; p++) begin
			addr = (p == 0) ? 32'd0 : (p == 3) ? '1 : $urandom;
			set_regs(PH_PRIO[p], PH_ADV[p], PH_PREEMPT[p], addr);
			@(negedge clk);
			idle_off = PH_NO_IDLE[p];
			event_q.push_back(mk_event(vrrp_pkg::FUNC_START, 1'b1, 8'd0, 32'd0,
				1'b1, 1'b0));
			repeat (PH_LEN[p] - 1)
				event_q.push_back(rand_event(PH_PRIO[p], addr));
			drain();
		end

		repeat (8) @(posedge clk);
		if (outcome_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
		if (n_mismatch == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
